/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the frame queue block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An invariant that is checked at every clock edge outside reset.
`define PFF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define PFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pff_pkg.sv */
// Shared constants and helpers for the per-port frame queue block.
// No dependencies; used by the top level and by the port checker.
package pff_pkg;

    localparam int PORTS_DEF      = 2;
    localparam int RX_DEPTH_DEF   = 16;
    localparam int TX_DEPTH_DEF   = 16;
    localparam int FRAME_BITS_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;
    localparam int LEVEL_W  = 5;
    localparam int WORD_W   = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_RX_INS   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RX_EXT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TX_INS   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TX_EXT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TX_QUERY = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic REG_RX_CAP = 1'b0;
    localparam logic REG_TX_CAP = 1'b1;

    // A capacity of zero acts as one, and one above the depth acts as the depth.
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c,
                                                   input int depth);
        logic [CAP_W-1:0] r;
        if (c == '0)
            r = CAP_W'(1);
        else if (int'(c) > depth)
            r = CAP_W'(depth);
        else
            r = c;
        return r;
    endfunction

endpackage

/* rtl/pff_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/per_port_frame_fifos.sv */
// Top level of the per-port frame queue block: pointers, counters and result stage.
// Depends on pff_pkg and on pff_ram for the receive and transmit frame stores.
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low. busy
//   stays low, so a new command may be given in every cycle: one item per cycle.
//   Each command gives exactly one result, shown for one cycle with done high in
//   the cycle after the command's transfer. That cycle is set by the registered
//   read of the frame store RAM, which an extract needs.
//   status, level and tx_full come from registers; frame_out is the RAM read
//   data, or zero when the command was not a successful extract.
//   The receiver cannot stall the result; it must take it in the cycle it shows.
//   Pointers and counters sit in flip-flops and are updated in the cycle of the
//   transfer, so a back-to-back insert and extract of the same entry needs no
//   forwarding: the write lands at the edge before the read address is sampled.
//   Capacities are written through cfg_we, cfg_addr and cfg_wdata while idle.
//   Reset empties every queue and sets both capacities to 16. The frame stores are
//   not cleared; the user must not read an entry before it is written (unchecked).
module per_port_frame_fifos #(
    parameter int PORTS      = pff_pkg::PORTS_DEF,
    parameter int RX_DEPTH   = pff_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH   = pff_pkg::TX_DEPTH_DEF,
    parameter int FRAME_BITS = pff_pkg::FRAME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pff_pkg::ACTION_W-1:0]  action,
    input  logic                          port,
    input  logic [pff_pkg::WORD_W-1:0]    frame_word,
    output logic                          done,
    output logic [pff_pkg::STATUS_W-1:0]  status,
    output logic [pff_pkg::LEVEL_W-1:0]   level,
    output logic [pff_pkg::WORD_W-1:0]    frame_out,
    output logic                          tx_full,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [pff_pkg::CAP_W-1:0]     cfg_wdata
);

    localparam int CAP_W    = pff_pkg::CAP_W;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CMP_W = (RX_PTR_W + 1 > CAP_W) ? RX_PTR_W + 1 : CAP_W;
    localparam int TX_CMP_W = (TX_PTR_W + 1 > CAP_W) ? TX_PTR_W + 1 : CAP_W;
    localparam int PIDX_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
    // The port field is one bit, so each store holds two port regions.
    localparam int RX_MEM_DEPTH = 2 << RX_PTR_W;
    localparam int TX_MEM_DEPTH = 2 << TX_PTR_W;

    logic [CAP_W-1:0]    rx_cap_reg, tx_cap_reg;
    logic [RX_PTR_W-1:0] rx_wp_reg [PORTS];
    logic [RX_PTR_W-1:0] rx_rp_reg [PORTS];
    logic [CAP_W-1:0]    rx_cnt_reg [PORTS];
    logic [TX_PTR_W-1:0] tx_wp_reg [PORTS];
    logic [TX_PTR_W-1:0] tx_rp_reg [PORTS];
    logic [CAP_W-1:0]    tx_cnt_reg [PORTS];

    logic                         done_reg;
    logic [pff_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pff_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic                         tx_full_reg, tx_full_next;
    logic                         rx_out_reg, rx_out_next;
    logic                         tx_out_reg, tx_out_next;

    logic                accept, port_ok;
    logic [PIDX_W-1:0]   pidx;
    logic [CAP_W-1:0]    rcap, tcap;
    logic [RX_PTR_W-1:0] rx_wp, rx_rp;
    logic [TX_PTR_W-1:0] tx_wp, tx_rp;
    logic [CAP_W-1:0]    rx_cnt, tx_cnt;
    logic                rx_is_full, tx_is_full;
    logic                rx_ins, rx_ext, tx_ins, tx_ext;

    logic                     rx_we, tx_we;
    logic [RX_PTR_W:0]        rx_waddr, rx_raddr;
    logic [TX_PTR_W:0]        tx_waddr, tx_raddr;
    logic [FRAME_BITS-1:0]    wdata, rx_q, tx_q;

    function automatic logic [RX_PTR_W-1:0] rx_adv(input logic [RX_PTR_W-1:0] p,
                                                   input logic [CAP_W-1:0] cap);
        logic [RX_CMP_W-1:0] n;
        n = RX_CMP_W'(p) + RX_CMP_W'(1);
        return (n >= RX_CMP_W'(cap)) ? '0 : RX_PTR_W'(n);
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_adv(input logic [TX_PTR_W-1:0] p,
                                                   input logic [CAP_W-1:0] cap);
        logic [TX_CMP_W-1:0] n;
        n = TX_CMP_W'(p) + TX_CMP_W'(1);
        return (n >= TX_CMP_W'(cap)) ? '0 : TX_PTR_W'(n);
    endfunction

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign port_ok = (int'(port) < PORTS);
    assign pidx    = port_ok ? PIDX_W'(port) : '0;

    assign rcap = pff_pkg::clamp_cap(rx_cap_reg, RX_DEPTH);
    assign tcap = pff_pkg::clamp_cap(tx_cap_reg, TX_DEPTH);

    assign rx_wp  = rx_wp_reg[pidx];
    assign rx_rp  = rx_rp_reg[pidx];
    assign rx_cnt = rx_cnt_reg[pidx];
    assign tx_wp  = tx_wp_reg[pidx];
    assign tx_rp  = tx_rp_reg[pidx];
    assign tx_cnt = tx_cnt_reg[pidx];

    assign rx_is_full = (rx_cnt >= rcap);
    assign tx_is_full = (tx_cnt >= tcap);

    // Successful queue operations of the command being transferred.
    assign rx_ins = accept && port_ok && (action == pff_pkg::ACT_RX_INS) && !rx_is_full;
    assign rx_ext = accept && port_ok && (action == pff_pkg::ACT_RX_EXT) && (rx_cnt != '0);
    assign tx_ins = accept && port_ok && (action == pff_pkg::ACT_TX_INS) && !tx_is_full;
    assign tx_ext = accept && port_ok && (action == pff_pkg::ACT_TX_EXT) && (tx_cnt != '0);

    assign wdata    = frame_word[FRAME_BITS-1:0];
    assign rx_we    = rx_ins;
    assign tx_we    = tx_ins;
    assign rx_waddr = {pidx[0], rx_wp};
    assign tx_waddr = {pidx[0], tx_wp};
    assign rx_raddr = {pidx[0], rx_rp};
    assign tx_raddr = {pidx[0], tx_rp};

    always_comb
    begin
        status_next  = pff_pkg::ST_DONE;
        level_next   = '0;
        tx_full_next = 1'b0;
        rx_out_next  = rx_ext;
        tx_out_next  = tx_ext;
        if (!port_ok)
        begin
            case (action) inside
                pff_pkg::ACT_RX_INS, pff_pkg::ACT_TX_INS: status_next = pff_pkg::ST_FULL;
                pff_pkg::ACT_RX_EXT, pff_pkg::ACT_TX_EXT: status_next = pff_pkg::ST_EMPTY;
                pff_pkg::ACT_TX_QUERY:                    tx_full_next = 1'b1;
                default:                                  status_next = pff_pkg::ST_DONE;
            endcase
        end
        else
        begin
            case (action)
                pff_pkg::ACT_RX_INS:
                begin
                    if (rx_is_full)
                        status_next = pff_pkg::ST_FULL;
                    else
                        level_next = rcap - rx_cnt - CAP_W'(1);
                end
                pff_pkg::ACT_RX_EXT:
                begin
                    if (rx_cnt == '0)
                        status_next = pff_pkg::ST_EMPTY;
                    else
                        level_next = rx_cnt - CAP_W'(1);
                end
                pff_pkg::ACT_TX_INS:
                begin
                    if (tx_is_full)
                        status_next = pff_pkg::ST_FULL;
                    else
                        level_next = tcap - tx_cnt - CAP_W'(1);
                end
                pff_pkg::ACT_TX_EXT:
                begin
                    if (tx_cnt == '0)
                        status_next = pff_pkg::ST_EMPTY;
                    else
                        level_next = tx_cnt - CAP_W'(1);
                end
                pff_pkg::ACT_TX_QUERY: tx_full_next = tx_is_full;
                default:               status_next = pff_pkg::ST_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cap_reg <= pff_pkg::CAP_RESET;
            tx_cap_reg <= pff_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pff_pkg::REG_RX_CAP: rx_cap_reg <= cfg_wdata;
                pff_pkg::REG_TX_CAP: tx_cap_reg <= cfg_wdata;
                default:             rx_cap_reg <= rx_cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                rx_wp_reg[i]  <= '0;
                rx_rp_reg[i]  <= '0;
                rx_cnt_reg[i] <= '0;
                tx_wp_reg[i]  <= '0;
                tx_rp_reg[i]  <= '0;
                tx_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (rx_ins)
            begin
                rx_wp_reg[pidx]  <= rx_adv(rx_wp, rcap);
                rx_cnt_reg[pidx] <= rx_cnt + CAP_W'(1);
            end
            if (rx_ext)
            begin
                rx_rp_reg[pidx]  <= rx_adv(rx_rp, rcap);
                rx_cnt_reg[pidx] <= rx_cnt - CAP_W'(1);
            end
            if (tx_ins)
            begin
                tx_wp_reg[pidx]  <= tx_adv(tx_wp, tcap);
                tx_cnt_reg[pidx] <= tx_cnt + CAP_W'(1);
            end
            if (tx_ext)
            begin
                tx_rp_reg[pidx]  <= tx_adv(tx_rp, tcap);
                tx_cnt_reg[pidx] <= tx_cnt - CAP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            rx_out_reg <= 1'b0;
            tx_out_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= accept;
            rx_out_reg <= rx_out_next;
            tx_out_reg <= tx_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            level_reg   <= level_next;
            tx_full_reg <= tx_full_next;
        end
    end

    pff_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (RX_MEM_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (wdata),
        .raddr (rx_raddr),
        .rdata (rx_q)
    );

    pff_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (TX_MEM_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (wdata),
        .raddr (tx_raddr),
        .rdata (tx_q)
    );

    assign done    = done_reg;
    assign status  = status_reg;
    assign level   = level_reg;
    assign tx_full = tx_full_reg;

    always_comb
    begin
        if (rx_out_reg)
            frame_out = pff_pkg::WORD_W'(rx_q);
        else if (tx_out_reg)
            frame_out = pff_pkg::WORD_W'(tx_q);
        else
            frame_out = '0;
    end

endmodule

/* rtl/pff_checker.sv */
// Port-level checker for per_port_frame_fifos, attached by the bind below.
// Depends on pff_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module pff_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [pff_pkg::ACTION_W-1:0]  action,
    input logic                          done,
    input logic [pff_pkg::STATUS_W-1:0]  status,
    input logic [pff_pkg::LEVEL_W-1:0]   level,
    input logic [pff_pkg::WORD_W-1:0]    frame_out,
    input logic                          tx_full
);

    logic xfer;
    logic ins_xfer;
    logic non_query;
    logic failed;
    logic clean;

    assign xfer      = start && !busy;
    assign ins_xfer  = xfer && ((action == pff_pkg::ACT_RX_INS) ||
                                (action == pff_pkg::ACT_TX_INS));
    assign non_query = xfer && (action != pff_pkg::ACT_TX_QUERY);
    assign failed    = done && (status != pff_pkg::ST_DONE);
    assign clean     = (level == '0) && (frame_out == '0);

    // Every transferred command gives a result in the next cycle, and nothing else does.
    `PFF_ASSERT_NEXT(a_result_follows, xfer, done, "transfer without a result")
    `PFF_ASSERT_NEXT(a_no_spurious, !xfer, !done, "result without a transfer")

    // A full or empty report carries no level and no frame.
    `PFF_ASSERT_ALWAYS(a_fail_clean, failed |-> clean, "failed operation carries data")

    // Only a query raises tx_full.
    `PFF_ASSERT_NEXT(a_query_only, non_query, !tx_full, "tx_full outside a query")

    // An insert never returns a frame.
    `PFF_ASSERT_NEXT(a_insert_no_frame, ins_xfer, frame_out == '0, "insert returned a frame")

endmodule

bind per_port_frame_fifos pff_checker u_pff_checker (.*);

/* test/per_port_frame_fifos_tb.sv */
// Self-checking testbench for per_port_frame_fifos: receive and transmit frame queues per port.
// Depends on pff_pkg and the block's RTL only; commands are predicted and results compared
// in order.
`timescale 1ns / 1ps

module per_port_frame_fifos_tb;

    localparam int ACTION_W = pff_pkg::ACTION_W;
    localparam int STATUS_W = pff_pkg::STATUS_W;
    localparam int LEVEL_W  = pff_pkg::LEVEL_W;
    localparam int WORD_W   = pff_pkg::WORD_W;
    localparam int CAP_W    = pff_pkg::CAP_W;
    localparam int PORTS_N  = pff_pkg::PORTS_DEF;
    localparam int RX_DEPTH = pff_pkg::RX_DEPTH_DEF;
    localparam int TX_DEPTH = pff_pkg::TX_DEPTH_DEF;

    localparam int RX_SIDE = 0;
    localparam int TX_SIDE = 1;
    localparam int MAX_DEPTH = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam int SEGMENT_ITEMS = 250;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic [WORD_W-1:0]   frame;
        logic                tx_full;
    } queue_result_t;

    class frame_queue_scoreboard;
        logic [WORD_W-1:0] frames[2][PORTS_N][MAX_DEPTH];
        bit                written[2][PORTS_N][MAX_DEPTH];
        int                wr_ptr[2][PORTS_N];
        int                rd_ptr[2][PORTS_N];
        int                count[2][PORTS_N];
        logic [CAP_W-1:0]  cap_reg[2];
        queue_result_t     pending_results[$];
        int errors;
        int commands;
        int extracted;
        int full_reports;
        int empty_reports;
        int full_flags;

        function new();
            cap_reg[RX_SIDE] = pff_pkg::CAP_RESET;
            cap_reg[TX_SIDE] = pff_pkg::CAP_RESET;
        endfunction

        function void set_capacity(logic idx, logic [CAP_W-1:0] value);
            cap_reg[idx == pff_pkg::REG_TX_CAP ? TX_SIDE : RX_SIDE] = value;
        endfunction

        function int usable_slots(int side);
            int depth;
            depth = (side == TX_SIDE) ? TX_DEPTH : RX_DEPTH;
            if (cap_reg[side] == '0)
                return 1;
            if (int'(cap_reg[side]) > depth)
                return depth;
            return int'(cap_reg[side]);
        endfunction

        // A non-empty queue whose read pointer sits on a slot never written must not be
        // extracted from.
        function bit extract_is_safe(logic [ACTION_W-1:0] act, logic prt);
            int side;
            int p;
            p = prt;
            if (act != pff_pkg::ACT_RX_EXT && act != pff_pkg::ACT_TX_EXT)
                return 1;
            side = (act == pff_pkg::ACT_TX_EXT) ? TX_SIDE : RX_SIDE;
            return count[side][p] == 0 || written[side][p][rd_ptr[side][p]];
        endfunction

        function void note_command(logic [ACTION_W-1:0] act, logic prt,
                                   logic [WORD_W-1:0] frame_in);
            queue_result_t r;
            int side;
            int p;
            int cap;
            r = '0;
            r.status = pff_pkg::ST_DONE;
            p = prt;
            side = (act == pff_pkg::ACT_TX_INS || act == pff_pkg::ACT_TX_EXT) ? TX_SIDE : RX_SIDE;
            cap = usable_slots(side);
            commands++;
            case (act)
                pff_pkg::ACT_RX_INS, pff_pkg::ACT_TX_INS:
                    if (count[side][p] >= cap)
                    begin
                        r.status = pff_pkg::ST_FULL;
                        full_reports++;
                    end
                    else
                    begin
                        frames[side][p][wr_ptr[side][p]] = frame_in;
                        written[side][p][wr_ptr[side][p]] = 1'b1;
                        wr_ptr[side][p] = (wr_ptr[side][p] + 1 >= cap) ? 0
                                                                      : wr_ptr[side][p] + 1;
                        count[side][p]++;
                        r.level = LEVEL_W'(cap - count[side][p]);
                    end
                pff_pkg::ACT_RX_EXT, pff_pkg::ACT_TX_EXT:
                    if (count[side][p] == 0)
                    begin
                        r.status = pff_pkg::ST_EMPTY;
                        empty_reports++;
                    end
                    else
                    begin
                        r.frame = frames[side][p][rd_ptr[side][p]];
                        rd_ptr[side][p] = (rd_ptr[side][p] + 1 >= cap) ? 0
                                                                      : rd_ptr[side][p] + 1;
                        count[side][p]--;
                        r.level = LEVEL_W'(count[side][p]);
                        extracted++;
                    end
                pff_pkg::ACT_TX_QUERY:
                begin
                    r.tx_full = count[TX_SIDE][p] >= usable_slots(TX_SIDE);
                    if (r.tx_full)
                        full_flags++;
                end
                default:
                    ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [LEVEL_W-1:0] lv,
                                   logic [WORD_W-1:0] fo, logic tf);
            queue_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d level %0d frame_out %h tx_full %0d",
                       st, lv, fo, tf);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (lv !== e.level)
            begin
                $error("level: expected %0d, actual %0d", e.level, lv);
                errors++;
            end
            if (fo !== e.frame)
            begin
                $error("frame_out: expected %h, actual %h", e.frame, fo);
                errors++;
            end
            if (tf !== e.tx_full)
            begin
                $error("tx_full: expected %0d, actual %0d", e.tx_full, tf);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACTION_W-1:0] action = '0;
    logic                port = 1'b0;
    logic [WORD_W-1:0]   frame_word = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  level;
    logic [WORD_W-1:0]   frame_out;
    logic                tx_full;
    logic                cfg_we = 1'b0;
    logic                cfg_addr = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;

    frame_queue_scoreboard sb = new();
    int settings_used = 1;

    per_port_frame_fifos uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .port       (port),
        .frame_word (frame_word),
        .done       (done),
        .status     (status),
        .level      (level),
        .frame_out  (frame_out),
        .tx_full    (tx_full),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(status, level, frame_out, tx_full);
    end

    // Holds the command until the transfer edge, then records it for prediction.
    task automatic send_command(logic [ACTION_W-1:0] act, logic prt, logic [WORD_W-1:0] frm);
        start      <= 1'b1;
        action     <= act;
        port       <= prt;
        frame_word <= frm;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(act, prt, frm);
    endtask

    // Idles with start low; the payload carries junk that must be ignored.
    task automatic idle_cycle();
        start      <= 1'b0;
        action     <= ACTION_W'($urandom);
        port       <= 1'($urandom);
        frame_word <= {$urandom, $urandom};
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacities(logic [CAP_W-1:0] rx_cap, logic [CAP_W-1:0] tx_cap);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= pff_pkg::REG_RX_CAP;
        cfg_wdata <= rx_cap;
        @(posedge clk);
        sb.set_capacity(pff_pkg::REG_RX_CAP, rx_cap);
        cfg_addr  <= pff_pkg::REG_TX_CAP;
        cfg_wdata <= tx_cap;
        @(posedge clk);
        sb.set_capacity(pff_pkg::REG_TX_CAP, tx_cap);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic random_segment(int idle_pct);
        int counted;
        int fill_pct;
        int r;
        bit to_tx;
        logic [ACTION_W-1:0] act;
        logic prt;
        counted = 0;
        fill_pct = 50;
        while (counted < SEGMENT_ITEMS)
        begin
            // The insert bias drifts so that queues swing between full and empty.
            if (counted % 40 == 0)
                fill_pct = $urandom_range(20, 80);
            r = $urandom_range(99);
            prt = 1'($urandom);
            if (r < 3)
            begin
                act = ACT_UNUSED_LO + ACTION_W'($urandom_range(2));
            end
            else if (r < 13)
            begin
                act = pff_pkg::ACT_TX_QUERY;
                counted++;
            end
            else
            begin
                to_tx = 1'($urandom);
                if ($urandom_range(99) < fill_pct)
                    act = to_tx ? pff_pkg::ACT_TX_INS : pff_pkg::ACT_RX_INS;
                else
                    act = to_tx ? pff_pkg::ACT_TX_EXT : pff_pkg::ACT_RX_EXT;
                if (!sb.extract_is_safe(act, prt))
                    act = pff_pkg::ACT_TX_QUERY;
                counted++;
            end
            while ($urandom_range(99) < idle_pct)
                idle_cycle();
            send_command(act, prt, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] rx_caps[6];
        logic [CAP_W-1:0] tx_caps[6];
        rx_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17};
        tx_caps = '{5'd3, 5'd16, 5'd31, 5'd0, 5'd1, 5'd17};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queues right after reset, and the unused action codes.
        send_command(pff_pkg::ACT_RX_EXT, 1'b0, '1);
        send_command(pff_pkg::ACT_TX_EXT, 1'b1, '0);
        send_command(pff_pkg::ACT_TX_QUERY, 1'b0, '1);
        send_command(ACT_UNUSED_LO, 1'b1, '1);
        send_command(ACT_UNUSED_LO + 3'd1, 1'b0, '1);
        send_command(ACT_UNUSED_LO + 3'd2, 1'b1, '1);
        // Extreme frame words through the receive queue, back to back.
        send_command(pff_pkg::ACT_RX_INS, 1'b0, '1);
        send_command(pff_pkg::ACT_RX_INS, 1'b0, '0);
        send_command(pff_pkg::ACT_RX_EXT, 1'b0, '0);
        send_command(pff_pkg::ACT_RX_EXT, 1'b0, '1);

        // Single-slot queues: full report, full query and its release.
        write_capacities(5'd1, 5'd1);
        send_command(pff_pkg::ACT_TX_INS, 1'b1, 64'hA5A5_5A5A_0123_4567);
        send_command(pff_pkg::ACT_TX_INS, 1'b1, 64'hFFFF_0000_FFFF_0000);
        send_command(pff_pkg::ACT_TX_QUERY, 1'b1, '0);
        send_command(pff_pkg::ACT_TX_EXT, 1'b1, '0);
        send_command(pff_pkg::ACT_TX_QUERY, 1'b1, '0);
        send_command(pff_pkg::ACT_RX_INS, 1'b1, 64'h8000_0000_0000_0001);
        send_command(pff_pkg::ACT_RX_INS, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE);
        send_command(pff_pkg::ACT_TX_EXT, 1'b0, '0);

        // Capacities change between segments while entries are still held.
        for (int seg = 0; seg < 6; seg++)
        begin
            write_capacities(rx_caps[seg], tx_caps[seg]);
            random_segment(seg < 2 ? 21 : (seg < 4 ? 83 : 0));
        end

        wait_for_results();
        if (sb.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.errors++;
        end
        $display("Ran %0d commands under %0d capacity settings.", sb.commands, settings_used);
        $display("Saw %0d extracted frames, %0d full and %0d empty reports, %0d full queries.",
                 sb.extracted, sb.full_reports, sb.empty_reports, sb.full_flags);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* per_port_frame_fifos.f */
+incdir+rtl
rtl/pff_pkg.sv
rtl/pff_ram.sv
rtl/per_port_frame_fifos.sv
rtl/pff_checker.sv
test/per_port_frame_fifos_tb.sv
